@@ rtl/core/btds_pkg.sv @@
package btds_pkg;

  // Configuration register indexes
  localparam logic [7:0] CFG_MODE       = 8'd0;
  localparam logic [7:0] CFG_SET_LENGTH = 8'd1;

  // Item kinds carried on tuser
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_PROCESS = 1'b1;

  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_DELETE    = 2'd1,
    MODE_SQUEEZE   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;    // write one set entry
    logic start;   // capture a stream byte and begin the scan
    logic latch;   // hold the scan result
    logic commit;  // decide, update squeeze memory, fill output register
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    logic [7:0] from_char;
    logic [7:0] to_char;
  } set_entry_t;

endpackage

@@ rtl/core/btds_ctrl.sv @@
module btds_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_action_i,
  input  btds_pkg::dp_sts_t sts_i,
  output logic              in_ready_o,
  output btds_pkg::dp_cmd_t cmd_o
);
  import btds_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i == ACT_PROCESS) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SCAN;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/btds_dpath.sv @@
module btds_dpath #(
  parameter int SET_SIZE = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  btds_pkg::dp_cmd_t cmd_i,
  output btds_pkg::dp_sts_t sts_o,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic [4:0]        entry_index_i,
  input  logic [7:0]        from_char_i,
  input  logic [7:0]        to_char_i,
  input  logic [7:0]        data_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o
);
  import btds_pkg::*;

  localparam int IDX_W = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
  localparam int CNT_W = $clog2(SET_SIZE + 1);

  set_entry_t set_mem [SET_SIZE];
  set_entry_t rdata_q;

  logic [1:0]       mode_q;
  logic [5:0]       set_length_q;
  logic [7:0]       byte_q;
  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] scan_idx_q;
  logic             rd_pend_q;
  logic             hit_q;
  logic [7:0]       repl_q;
  logic [7:0]       last_sq_q, last_sq_d;
  logic             held_q, held_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q;

  logic             issue;
  logic             match;
  logic             keep;
  logic [7:0]       result;
  logic             wr_ok;

  assign wr_ok = cmd_i.load && (int'(entry_index_i) < SET_SIZE);
  assign issue = (scan_idx_q < n_q);
  assign match = rd_pend_q && (rdata_q.from_char == byte_q);

  assign sts_o.scan_done = match || (!rd_pend_q && !issue);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Set store: one write port for loads, one registered read for the scan
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      set_mem[IDX_W'(entry_index_i)] <= '{from_char: from_char_i, to_char: to_char_i};
    end
    rdata_q <= set_mem[scan_idx_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_TRANSLATE;
      set_length_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE:       mode_q       <= cfg_data_i[1:0];
        CFG_SET_LENGTH: set_length_q <= cfg_data_i[5:0];
        default:        ;
      endcase
    end
  end

  // Scan pointer and compare pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      rd_pend_q  <= 1'b0;
    end else if (cmd_i.start) begin
      scan_idx_q <= '0;
      rd_pend_q  <= 1'b0;
    end else begin
      rd_pend_q <= issue;
      if (issue) begin
        scan_idx_q <= CNT_W'(scan_idx_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      byte_q <= data_byte_i;
      n_q    <= (int'(set_length_q) > SET_SIZE) ? CNT_W'(SET_SIZE) : CNT_W'(set_length_q);
    end
    if (cmd_i.latch) begin
      hit_q  <= match;
      repl_q <= rdata_q.to_char;
    end
    if (cmd_i.commit) begin
      out_byte_q <= result;
    end
  end

  always_comb begin
    keep      = 1'b1;
    result    = byte_q;
    last_sq_d = last_sq_q;
    held_d    = held_q;
    case (mode_q)
      MODE_TRANSLATE: begin
        if (hit_q) begin
          result = repl_q;
        end
      end
      MODE_DELETE: begin
        keep = !hit_q;
      end
      MODE_SQUEEZE: begin
        if (hit_q) begin
          keep      = !(held_q && (last_sq_q == byte_q));
          last_sq_d = byte_q;
          held_d    = 1'b1;
        end else begin
          last_sq_d = '0;
          held_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.commit && keep) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sq_q   <= '0;
      held_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.commit) begin
        last_sq_q <= last_sq_d;
        held_q    <= held_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;

endmodule

@@ rtl/core/byte_translate_delete_squeeze.sv @@
// A load transaction is taken without a scan and the next item may follow at once.
// A process transaction scans up to n = min(set_length, SET_SIZE) set entries, then
// fills the output register, and the next item is taken only once that is done:
// the set store is read one entry per cycle through its single registered read
// port, a hit ends the scan early and a stalled output holds it.
// Reset clears controller, configuration, squeeze memory and output valid, not the set store.
module byte_translate_delete_squeeze #(
  parameter int SET_SIZE = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // entry_index, from_char, to_char, data_byte, zero pad
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import btds_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  btds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  btds_dpath #(
    .SET_SIZE (SET_SIZE)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .entry_index_i (s_axis_tdata[4:0]),
    .from_char_i   (s_axis_tdata[12:5]),
    .to_char_i     (s_axis_tdata[20:13]),
    .data_byte_i   (s_axis_tdata[28:21]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (m_axis_tdata)
  );

endmodule

@@ rtl/core/btds_checker.sv @@
module btds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);
  import btds_pkg::*;

  // a process transaction occupies the block while the set is scanned
  a_busy_after_process: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_PROCESS) |=> !s_axis_tready)
    else $error("input accepted during a scan");

  // a load transaction never blocks the stream
  a_load_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_LOAD) |=> s_axis_tready)
    else $error("load transaction stalled input");

  // a new result only appears as a scan completes
  a_result_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a preceding scan");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

endmodule

bind byte_translate_delete_squeeze btds_checker u_chk (.*);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import btds_pkg::*;

  localparam int SET_SIZE = 32;
  localparam int DRAIN_CYCLES = 40;      // longest scan plus output register, with margin
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEMS_PER_SETTING = 75;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_LOAD,
    ROW_PROC
  } row_kind_e;

  typedef enum logic [1:0] {
    CHK_PRED,  // compare against the predictor
    CHK_BYTE,  // compare against the typed byte
    CHK_NONE   // byte must be dropped
  } chk_e;

  typedef struct {
    row_kind_e  kind;
    logic [7:0] f0;  // register index, entry index or stream byte
    logic [7:0] f1;  // register value or source character
    logic [7:0] f2;  // replacement character
    chk_e       chk;
    logic [7:0] want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;

  // predictor state
  logic [7:0] src_tab [SET_SIZE];
  logic [7:0] rep_tab [SET_SIZE];
  logic [7:0] sq_last;
  bit         sq_held;
  logic [1:0] cur_mode;
  logic [5:0] set_len;

  logic [7:0] pending_out [$];
  stim_row_t  directed_rows [$];
  int         bad_count;
  int         src_idle_pct;
  int         snk_stall_pct;
  bit         hold_req;
  int         hold_left;

  byte_translate_delete_squeeze #(
    .SET_SIZE(SET_SIZE)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void note_bad(input string msg);
    if (bad_count < 10) $display("%s", msg);
    bad_count++;
  endfunction

  // Returns 1 when the byte is kept; updates the squeeze memory.
  function automatic bit filter_byte(input logic [7:0] c, output logic [7:0] res);
    int n;
    int hit_at;
    bit rpt;
    n = (set_len > SET_SIZE) ? SET_SIZE : int'(set_len);
    hit_at = -1;
    for (int i = 0; i < n; i++) begin
      if (hit_at < 0 && src_tab[i] == c) hit_at = i;
    end
    res = c;
    case (cur_mode)
      MODE_TRANSLATE: begin
        if (hit_at >= 0) res = rep_tab[hit_at];
        return 1'b1;
      end
      MODE_DELETE: return hit_at < 0;
      MODE_SQUEEZE: begin
        if (hit_at >= 0) begin
          rpt = sq_held && sq_last == c;
          sq_last = c;
          sq_held = 1'b1;
          return !rpt;
        end
        sq_held = 1'b0;
        sq_last = '0;
        return 1'b1;
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic void add_row(input row_kind_e kind, input logic [7:0] f0,
                                  input logic [7:0] f1, input logic [7:0] f2,
                                  input chk_e chk, input logic [7:0] want);
    stim_row_t r;
    r.kind = kind;
    r.f0 = f0;
    r.f1 = f1;
    r.f2 = f2;
    r.chk = chk;
    r.want = want;
    directed_rows.push_back(r);
  endfunction

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_MODE) cur_mode = val[1:0];
    else if (idx == CFG_SET_LENGTH) set_len = val[5:0];
  endtask

  task automatic offer(input logic act, input logic [4:0] entry, input logic [7:0] from_c,
                       input logic [7:0] to_c, input logic [7:0] data,
                       input chk_e chk, input logic [7:0] want);
    logic [7:0] res;
    bit         kept;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {3'b000, data, to_c, from_c, entry};
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == ACT_LOAD) begin
      src_tab[entry] = from_c;
      rep_tab[entry] = to_c;
    end else begin
      kept = filter_byte(data, res);
      case (chk)
        CHK_BYTE: pending_out.push_back(want);
        CHK_NONE: ;
        default: if (kept) pending_out.push_back(res);
      endcase
    end
  endtask

  // output side: check, then decide tready for the next edge
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_out.size() == 0)
          note_bad($sformatf("unexpected output byte %02h", m_axis_tdata));
        else if (pending_out[0] !== m_axis_tdata)
          note_bad($sformatf("out_byte mismatch: expected %02h got %02h",
                             pending_out.pop_front(), m_axis_tdata));
        else
          void'(pending_out.pop_front());
      end
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  initial begin
    int         src_pct [4];
    int         snk_pct [4];
    logic [7:0] prev_byte;
    logic [7:0] data;
    logic [5:0] len_pick;
    int         n;
    stim_row_t  r;

    src_pct = '{0, 82, 0, 25};
    snk_pct = '{0, 0, 82, 25};
    bad_count = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_req = 1'b0;
    hold_left = 0;
    for (int i = 0; i < SET_SIZE; i++) begin
      src_tab[i] = '0;
      rep_tab[i] = '0;
    end
    sq_last = '0;
    sq_held = 1'b0;
    cur_mode = MODE_TRANSLATE;
    set_len = '0;

    // after reset: translate with an empty set passes bytes through
    add_row(ROW_PROC, 8'h00, 8'h00, 8'h00, CHK_BYTE, 8'h00);
    add_row(ROW_PROC, 8'hFF, 8'h00, 8'h00, CHK_BYTE, 8'hFF);
    // fill the whole store so no scan ever reads an unwritten entry
    for (int i = 0; i < SET_SIZE; i++)
      add_row(ROW_LOAD, 8'(i), 8'(8'h40 + i), 8'(8'h60 + i), CHK_PRED, 8'h00);
    add_row(ROW_LOAD, 8'd0, 8'h00, 8'hFF, CHK_PRED, 8'h00);
    add_row(ROW_LOAD, 8'd31, 8'hFF, 8'h00, CHK_PRED, 8'h00);
    add_row(ROW_LOAD, 8'd1, 8'h41, 8'h7A, CHK_PRED, 8'h00);
    add_row(ROW_LOAD, 8'd2, 8'h41, 8'h11, CHK_PRED, 8'h00);
    add_row(ROW_CFG, CFG_MODE, 8'(MODE_TRANSLATE), 8'h00, CHK_PRED, 8'h00);
    add_row(ROW_CFG, CFG_SET_LENGTH, 8'd32, 8'h00, CHK_PRED, 8'h00);
    add_row(ROW_PROC, 8'h00, 8'h00, 8'h00, CHK_BYTE, 8'hFF);
    add_row(ROW_PROC, 8'hFF, 8'h00, 8'h00, CHK_BYTE, 8'h00);
    add_row(ROW_PROC, 8'h41, 8'h00, 8'h00, CHK_PRED, 8'h00);  // duplicate source, lowest wins
    add_row(ROW_PROC, 8'h20, 8'h00, 8'h00, CHK_BYTE, 8'h20);
    add_row(ROW_CFG, CFG_SET_LENGTH, 8'd63, 8'h00, CHK_PRED, 8'h00);  // clamps to store size
    add_row(ROW_PROC, 8'hFF, 8'h00, 8'h00, CHK_BYTE, 8'h00);
    add_row(ROW_CFG, CFG_SET_LENGTH, 8'd0, 8'h00, CHK_PRED, 8'h00);
    add_row(ROW_PROC, 8'h00, 8'h00, 8'h00, CHK_BYTE, 8'h00);
    add_row(ROW_CFG, CFG_MODE, 8'(MODE_DELETE), 8'h00, CHK_PRED, 8'h00);
    add_row(ROW_CFG, CFG_SET_LENGTH, 8'd32, 8'h00, CHK_PRED, 8'h00);
    add_row(ROW_PROC, 8'h00, 8'h00, 8'h00, CHK_NONE, 8'h00);
    add_row(ROW_PROC, 8'h7E, 8'h00, 8'h00, CHK_BYTE, 8'h7E);
    // squeeze memory starts empty, a byte outside the set clears it
    add_row(ROW_CFG, CFG_MODE, 8'(MODE_SQUEEZE), 8'h00, CHK_PRED, 8'h00);
    add_row(ROW_PROC, 8'h00, 8'h00, 8'h00, CHK_BYTE, 8'h00);
    add_row(ROW_PROC, 8'h00, 8'h00, 8'h00, CHK_NONE, 8'h00);
    add_row(ROW_PROC, 8'h00, 8'h00, 8'h00, CHK_NONE, 8'h00);
    add_row(ROW_PROC, 8'h20, 8'h00, 8'h00, CHK_BYTE, 8'h20);
    add_row(ROW_PROC, 8'h00, 8'h00, 8'h00, CHK_BYTE, 8'h00);
    add_row(ROW_PROC, 8'hFF, 8'h00, 8'h00, CHK_BYTE, 8'hFF);
    add_row(ROW_PROC, 8'h00, 8'h00, 8'h00, CHK_BYTE, 8'h00);
    add_row(ROW_LOAD, 8'd5, 8'h45, 8'h65, CHK_PRED, 8'h00);  // load leaves memory alone
    add_row(ROW_PROC, 8'h00, 8'h00, 8'h00, CHK_NONE, 8'h00);
    add_row(ROW_CFG, CFG_MODE, 8'(MODE_SPARE), 8'h00, CHK_PRED, 8'h00);
    add_row(ROW_PROC, 8'h00, 8'h00, 8'h00, CHK_BYTE, 8'h00);
    add_row(ROW_CFG, CFG_MODE, 8'(MODE_SQUEEZE), 8'h00, CHK_PRED, 8'h00);
    add_row(ROW_PROC, 8'h00, 8'h00, 8'h00, CHK_NONE, 8'h00);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      case (r.kind)
        ROW_CFG:  write_reg(r.f0, r.f1);
        ROW_LOAD: offer(ACT_LOAD, r.f0[4:0], r.f1, r.f2, 8'($urandom), r.chk, r.want);
        default:  offer(ACT_PROCESS, 5'($urandom), 8'($urandom), 8'($urandom), r.f0,
                        r.chk, r.want);
      endcase
    end

    prev_byte = '0;
    for (int ph = 0; ph < 4; ph++) begin
      for (int sub = 0; sub < 3; sub++) begin
        case ($urandom_range(0, 6))
          0: len_pick = 6'd0;
          1: len_pick = 6'd1;
          2: len_pick = 6'd31;
          3: len_pick = 6'd32;
          4: len_pick = 6'd33;
          5: len_pick = 6'd63;
          default: len_pick = 6'($urandom_range(0, 63));
        endcase
        write_reg(CFG_SET_LENGTH, {2'b00, len_pick});
        if (ph == 0 && sub == 0) write_reg(CFG_MODE, 8'(MODE_TRANSLATE));
        else write_reg(CFG_MODE, 8'($urandom_range(0, 3)));
        src_idle_pct = src_pct[ph];
        snk_stall_pct = snk_pct[ph];
        // long output stall while the input keeps offering: fill the block
        if (ph == 0 && sub == 0) hold_req = 1'b1;
        n = (set_len > SET_SIZE) ? SET_SIZE : int'(set_len);
        for (int k = 0; k < ITEMS_PER_SETTING; k++) begin
          if ($urandom_range(0, 99) < 12) begin
            offer(ACT_LOAD, 5'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  CHK_PRED, 8'h00);
          end else begin
            case ($urandom_range(0, 3))
              0, 1: data = prev_byte;  // runs for squeeze
              2: data = (n > 0) ? src_tab[$urandom_range(0, n - 1)] : 8'($urandom);
              default: data = 8'($urandom);
            endcase
            if ($urandom_range(0, 9) == 0 && n > 0) data = src_tab[$urandom_range(0, n - 1)];
            offer(ACT_PROCESS, 5'($urandom), 8'($urandom), 8'($urandom), data,
                  CHK_PRED, 8'h00);
            prev_byte = data;
          end
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_out.size() != 0)
      note_bad($sformatf("%0d expected bytes never arrived", pending_out.size()));
    if (bad_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
